// ----- hw/rtl/fbcf_pkg.sv -----
// Package for the FIR block convolution filter.
// Holds the widths, the configuration constants and the command struct
// shared by the controller, the datapath and the top level.
`default_nettype none

package fbcf_pkg;

  localparam int SampleW   = 16;
  localparam int CoefW     = 16;
  localparam int ProdW     = SampleW + CoefW;
  localparam int AccW      = 48;
  localparam int FracBits  = 15;
  localparam int CoefWords = 8;
  localparam int TapsPerWord = 4;
  localparam int CoefWordW = CoefW * TapsPerWord;
  localparam int CoefSelW  = 3;
  localparam int CfgIdxW   = 4;
  localparam int TapIdxW   = 5;

  typedef struct packed {
    logic                 shift_in;
    logic                 clear_acc;
    logic                 mac_en;
    logic                 load_out;
    logic [TapIdxW-1:0]   tap_idx;
  } fbcf_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fbcf_ctrl.sv -----
// Controller for the FIR block convolution filter.
// Sequences sample intake, one multiply-accumulate per tap and the output
// transaction; depends on fbcf_pkg.
`default_nettype none

module fbcf_ctrl
  import fbcf_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output fbcf_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [TapIdxW-1:0] LastTap = TapIdxW'(TAPS - 1);

  logic [1:0]         state_r, state_nxt;
  logic [TapIdxW-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_tready     = 1'b0;
    cmd.shift_in  = 1'b0;
    cmd.clear_acc = 1'b0;
    cmd.mac_en    = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.tap_idx   = cnt_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.shift_in  = 1'b1;
          cmd.clear_acc = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        if (cnt_r == LastTap) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fbcf_datapath.sv -----
// Datapath for the FIR block convolution filter.
// Holds the coefficient registers, the delay line, the shared multiply-
// accumulate unit and the output register; depends on fbcf_pkg.
`default_nettype none

module fbcf_datapath
  import fbcf_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fbcf_cmd_t             cmd,
  input  wire logic [SampleW-1:0]    sample_in,
  input  wire logic                  cfg_wr,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CoefWordW-1:0]  cfg_data,
  output logic [SampleW-1:0]         sample_out,
  output logic                       saturated
);

  localparam int DlIdxW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int QW     = AccW - FracBits;

  logic [CoefWordW-1:0]       coef_r [CoefWords];
  logic signed [SampleW-1:0]  dl_r [TAPS];
  logic signed [AccW-1:0]     acc_r;
  logic [SampleW-1:0]         sample_r;
  logic                       sat_r;

  logic [CoefWordW-1:0]       coef_word;
  logic signed [CoefW-1:0]    tap;
  logic signed [SampleW-1:0]  dl_tap;
  logic signed [ProdW-1:0]    prod;
  logic signed [AccW-1:0]     rounded;
  logic [QW-1:0]              q;
  logic                       in_range;
  logic [SampleW-1:0]         sample_nxt;

  always_comb begin
    coef_word  = coef_r[cmd.tap_idx[TapIdxW-1:2]];
    tap        = coef_word[cmd.tap_idx[1:0]*CoefW +: CoefW];
    dl_tap     = dl_r[cmd.tap_idx[DlIdxW-1:0]];
    prod       = tap * dl_tap;
    rounded    = acc_r + AccW'(signed'(1 << (FracBits - 1)));
    q          = rounded[AccW-1:FracBits];
    in_range   = (q[QW-1:SampleW-1] == '0) || (q[QW-1:SampleW-1] == '1);
    if (in_range) begin
      sample_nxt = q[SampleW-1:0];
    end else if (q[QW-1]) begin
      sample_nxt = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      sample_nxt = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CoefWords; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr && !cfg_index[CfgIdxW-1]) begin
      coef_r[cfg_index[CoefSelW-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        dl_r[i] <= '0;
      end
    end else if (cmd.shift_in) begin
      dl_r[0] <= sample_in;
      for (int i = 1; i < TAPS; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc_r <= '0;
    end else if (cmd.mac_en) begin
      acc_r <= acc_r + AccW'(prod);
    end
    if (cmd.load_out) begin
      sample_r <= sample_nxt;
      sat_r    <= !in_range;
    end
  end

  assign sample_out = sample_r;
  assign saturated  = sat_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fir_block_convolution_filter.sv -----
// Sequence: after the input transaction the controller steps S_MAC through the taps, and
// S_DONE then loads the output register that drives out_tvalid. A new sample is taken only
// in S_IDLE, once the single shared multiply-accumulate unit (one tap a cycle) is done.
// A result that waits on out_tready holds the next result in S_DONE until it is taken.
// Reset: rst_n is synchronous and active low; it clears the coefficients, the
// delay line and all control state. Configuration writes complete every cycle.
`default_nettype none

module fir_block_convolution_filter
  import fbcf_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [15:0] sample_in
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [15:0]                out_tdata,  // [15:0] sample_out
  output logic                       out_tuser,  // [0] saturated
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CoefWordW-1:0]  cfg_data
);

  fbcf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  fbcf_ctrl #(
    .TAPS(TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  fbcf_datapath #(
    .TAPS(TAPS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sample_in (in_tdata),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_out(out_tdata),
    .saturated (out_tuser)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("Input accepted while a sample is being processed.");

  a_mac_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_en |-> !in_tready)
    else $error("Accumulation running while the input is ready.");

  a_out_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !cmd.load_out) |=> !out_tvalid)
    else $error("Result repeated after its transaction.");
`endif

endmodule

`default_nettype wire
